// ----- sv/rmst_pkg.sv -----
// ----------------------------------------------------------------------------
// rmst_pkg
// shared types and constants for the range max segment tree
// ----------------------------------------------------------------------------
package rmst_pkg;

    localparam int CAPACITY_DEF = 65536;
    localparam int VALUE_W      = 31;
    localparam int POS_W        = 17;

    localparam logic [POS_W-1:0] COUNT_RESET = 17'h10000;

    typedef enum logic {
        CMD_WRITE = 1'b0,
        CMD_QUERY = 1'b1
    } cmd_kind_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_W_RD,
        ST_W_UP,
        ST_Q_RUN,
        ST_DONE
    } state_t;

    typedef struct packed {
        cmd_kind_t          cmd;
        logic [POS_W-1:0]   range_high;
        logic [POS_W-1:0]   range_low;
        logic [VALUE_W-1:0] value;
        logic [POS_W-1:0]   position;
    } item_t;

    typedef struct packed {
        logic               range_error;
        logic [VALUE_W-1:0] max_value;
    } result_t;

endpackage

// ----- sv/range_max_segment_tree.sv -----
// ----------------------------------------------------------------------------
// range_max_segment_tree
// max segment tree with point writes and inclusive range maximum queries
// ----------------------------------------------------------------------------
//  channel  direction  item
//  s_       in         write (value at position) or query (range_low..range_high)
//  m_       out        max_value and range_error, one per query
//  cfg_     in         element_count
//
//  a write stores the leaf, then does one ram read and one write per level
//  a query does two ram reads per level
//  a bad write is dropped in idle, a bad query skips the tree and answers with range_error
//  after reset a clearing pass zeroes all 2*CAPACITY ram entries, s_tready low
//  a query result waits in the output register while writes keep going
// ----------------------------------------------------------------------------
module range_max_segment_tree #(
    parameter int CAPACITY = rmst_pkg::CAPACITY_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [87:0]                  s_tdata,  // position, value, range_low, range_high
    input  logic                         s_tuser,  // cmd
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [31:0]                  m_tdata,  // max_value
    output logic                         m_tuser,  // range_error
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [rmst_pkg::POS_W-1:0]   cfg_data
);

    localparam int NODE_W = $clog2(2 * CAPACITY);

    logic [rmst_pkg::POS_W-1:0]   count_reg;
    logic                         m_valid_reg;
    rmst_pkg::result_t            out_reg;
    rmst_pkg::item_t              item;
    rmst_pkg::result_t            res;
    logic                         res_valid;
    logic                         res_ready;
    logic                         mem_we;
    logic [NODE_W-1:0]            mem_waddr;
    logic [rmst_pkg::VALUE_W-1:0] mem_wdata;
    logic [NODE_W-1:0]            mem_raddr_a;
    logic [NODE_W-1:0]            mem_raddr_b;
    logic [rmst_pkg::VALUE_W-1:0] mem_rdata_a;
    logic [rmst_pkg::VALUE_W-1:0] mem_rdata_b;

    assign item      = rmst_pkg::item_t'({s_tuser, s_tdata[81:0]});
    assign cfg_ready = 1'b1;
    assign res_ready = !m_valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= rmst_pkg::COUNT_RESET;
        end else if (cfg_valid) begin
            count_reg <= cfg_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (res_ready) begin
            m_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_valid && res_ready) begin
            out_reg <= res;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {1'b0, out_reg.max_value};
    assign m_tuser  = out_reg.range_error;

    rmst_ctrl #(
        .CAPACITY (CAPACITY)
    ) u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .count       (count_reg),
        .in_valid    (s_tvalid),
        .in_ready    (s_tready),
        .in_item     (item),
        .res_valid   (res_valid),
        .res_ready   (res_ready),
        .res         (res),
        .mem_we      (mem_we),
        .mem_waddr   (mem_waddr),
        .mem_wdata   (mem_wdata),
        .mem_raddr_a (mem_raddr_a),
        .mem_raddr_b (mem_raddr_b),
        .mem_rdata_a (mem_rdata_a),
        .mem_rdata_b (mem_rdata_b)
    );

    rmst_node_ram #(
        .DEPTH  (2 * CAPACITY),
        .ADDR_W (NODE_W)
    ) u_ram (
        .aclk      (aclk),
        .wr_en     (mem_we),
        .wr_addr   (mem_waddr),
        .wr_data   (mem_wdata),
        .rd_addr_a (mem_raddr_a),
        .rd_addr_b (mem_raddr_b),
        .rd_data_a (mem_rdata_a),
        .rd_data_b (mem_rdata_b)
    );

endmodule

// ----- sv/rmst_node_ram.sv -----
// ----------------------------------------------------------------------------
// rmst_node_ram
// tree node storage, one write port and two registered read ports
// ----------------------------------------------------------------------------
module rmst_node_ram #(
    parameter int DEPTH  = 2 * rmst_pkg::CAPACITY_DEF,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic                         aclk,
    input  logic                         wr_en,
    input  logic [ADDR_W-1:0]            wr_addr,
    input  logic [rmst_pkg::VALUE_W-1:0] wr_data,
    input  logic [ADDR_W-1:0]            rd_addr_a,
    input  logic [ADDR_W-1:0]            rd_addr_b,
    output logic [rmst_pkg::VALUE_W-1:0] rd_data_a,
    output logic [rmst_pkg::VALUE_W-1:0] rd_data_b
);

    logic [rmst_pkg::VALUE_W-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        rd_data_a <= mem[rd_addr_a];
        rd_data_b <= mem[rd_addr_b];
    end

endmodule

// ----- sv/rmst_ctrl.sv -----
// ----------------------------------------------------------------------------
// rmst_ctrl
// sequencer for clearing, point writes and range queries over the node ram
// ----------------------------------------------------------------------------
module rmst_ctrl #(
    parameter  int CAPACITY = rmst_pkg::CAPACITY_DEF,
    localparam int NODE_W   = $clog2(2 * CAPACITY)
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic [rmst_pkg::POS_W-1:0]   count,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  rmst_pkg::item_t              in_item,
    output logic                         res_valid,
    input  logic                         res_ready,
    output rmst_pkg::result_t            res,
    output logic                         mem_we,
    output logic [NODE_W-1:0]            mem_waddr,
    output logic [rmst_pkg::VALUE_W-1:0] mem_wdata,
    output logic [NODE_W-1:0]            mem_raddr_a,
    output logic [NODE_W-1:0]            mem_raddr_b,
    input  logic [rmst_pkg::VALUE_W-1:0] mem_rdata_a,
    input  logic [rmst_pkg::VALUE_W-1:0] mem_rdata_b
);

    localparam int LR_W  = NODE_W + 1;
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int EW    = (CNT_W > rmst_pkg::POS_W) ? CNT_W : rmst_pkg::POS_W;
    localparam int SUM_W = ((EW > LR_W) ? EW : LR_W) + 1;
    localparam int VW    = rmst_pkg::VALUE_W;

    localparam logic [EW-1:0]     CAP_E     = EW'(CAPACITY);
    localparam logic [SUM_W-1:0]  CAP_S     = SUM_W'(CAPACITY);
    localparam logic [NODE_W-1:0] LAST_NODE = NODE_W'(2 * CAPACITY - 1);
    localparam logic [NODE_W-1:0] ROOT_NODE = NODE_W'(1);

    rmst_pkg::state_t  state_reg, state_next;
    logic [NODE_W-1:0] clr_reg, clr_next;
    logic [NODE_W-1:0] node_reg, node_next;
    logic [VW-1:0]     cur_reg, cur_next;
    logic [LR_W-1:0]   left_reg, left_next;
    logic [LR_W-1:0]   right_reg, right_next;
    logic [VW-1:0]     best_reg, best_next;
    logic              use_l_reg, use_l_next;
    logic              use_r_reg, use_r_next;
    logic              err_reg, err_next;

    logic [EW-1:0]     eff;
    logic [EW-1:0]     pos_e, lo_e, hi_e;
    logic              pos_ok, query_bad;
    logic [SUM_W-1:0]  leaf_sum, left_sum, right_sum;
    logic [VW-1:0]     sib_max, fold_a, fold_b;
    logic [NODE_W-1:0] parent;

    assign eff   = (EW'(count) > CAP_E) ? CAP_E : EW'(count);
    assign pos_e = EW'(in_item.position);
    assign lo_e  = EW'(in_item.range_low);
    assign hi_e  = EW'(in_item.range_high);

    assign pos_ok    = (pos_e != '0) && (pos_e <= eff);
    assign query_bad = (lo_e == '0) || (lo_e > hi_e) || (hi_e > eff);

    assign leaf_sum  = CAP_S + SUM_W'(in_item.position) - SUM_W'(1);
    assign left_sum  = CAP_S + SUM_W'(in_item.range_low) - SUM_W'(1);
    assign right_sum = CAP_S + SUM_W'(in_item.range_high);

    assign sib_max = (mem_rdata_a > cur_reg) ? mem_rdata_a : cur_reg;
    assign parent  = node_reg >> 1;

    // fold the node values read in the previous cycle
    assign fold_a = (use_l_reg && (mem_rdata_a > best_reg)) ? mem_rdata_a : best_reg;
    assign fold_b = (use_r_reg && (mem_rdata_b > fold_a)) ? mem_rdata_b : fold_a;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= rmst_pkg::ST_CLEAR;
            clr_reg   <= '0;
            use_l_reg <= 1'b0;
            use_r_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            use_l_reg <= use_l_next;
            use_r_reg <= use_r_next;
        end
    end

    always_ff @(posedge aclk) begin
        node_reg  <= node_next;
        cur_reg   <= cur_next;
        left_reg  <= left_next;
        right_reg <= right_next;
        best_reg  <= best_next;
        err_reg   <= err_next;
    end

    always_comb begin
        state_next  = state_reg;
        clr_next    = clr_reg;
        node_next   = node_reg;
        cur_next    = cur_reg;
        left_next   = left_reg;
        right_next  = right_reg;
        best_next   = best_reg;
        use_l_next  = 1'b0;
        use_r_next  = 1'b0;
        err_next    = err_reg;
        in_ready    = 1'b0;
        res_valid   = 1'b0;
        mem_we      = 1'b0;
        mem_waddr   = node_reg;
        mem_wdata   = cur_reg;
        mem_raddr_a = node_reg ^ NODE_W'(1);
        mem_raddr_b = node_reg;

        unique case (state_reg)
            rmst_pkg::ST_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = clr_reg;
                mem_wdata = '0;
                clr_next  = clr_reg + NODE_W'(1);
                if (clr_reg == LAST_NODE) begin
                    state_next = rmst_pkg::ST_IDLE;
                end
            end
            rmst_pkg::ST_IDLE: begin
                in_ready = 1'b1;
                if (in_valid) begin
                    if (in_item.cmd == rmst_pkg::CMD_WRITE) begin
                        if (pos_ok) begin
                            mem_we     = 1'b1;
                            mem_waddr  = leaf_sum[NODE_W-1:0];
                            mem_wdata  = in_item.value;
                            node_next  = leaf_sum[NODE_W-1:0];
                            cur_next   = in_item.value;
                            state_next = rmst_pkg::ST_W_RD;
                        end
                    end else if (query_bad) begin
                        err_next   = 1'b1;
                        best_next  = '0;
                        state_next = rmst_pkg::ST_DONE;
                    end else begin
                        err_next   = 1'b0;
                        best_next  = '0;
                        left_next  = left_sum[LR_W-1:0];
                        right_next = right_sum[LR_W-1:0];
                        state_next = rmst_pkg::ST_Q_RUN;
                    end
                end
            end
            rmst_pkg::ST_W_RD: begin
                // sibling of the node on the path
                state_next = rmst_pkg::ST_W_UP;
            end
            rmst_pkg::ST_W_UP: begin
                mem_we    = 1'b1;
                mem_waddr = parent;
                mem_wdata = sib_max;
                cur_next  = sib_max;
                node_next = parent;
                if (parent == ROOT_NODE) begin
                    state_next = rmst_pkg::ST_IDLE;
                end else begin
                    state_next = rmst_pkg::ST_W_RD;
                end
            end
            rmst_pkg::ST_Q_RUN: begin
                best_next   = fold_b;
                mem_raddr_a = left_reg[NODE_W-1:0];
                mem_raddr_b = NODE_W'(right_reg - LR_W'(1));
                if (left_reg < right_reg) begin
                    use_l_next = left_reg[0];
                    use_r_next = right_reg[0];
                    left_next  = (left_reg + LR_W'(1)) >> 1;
                    right_next = right_reg >> 1;
                end else begin
                    state_next = rmst_pkg::ST_DONE;
                end
            end
            rmst_pkg::ST_DONE: begin
                res_valid = 1'b1;
                if (res_ready) begin
                    state_next = rmst_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = rmst_pkg::ST_IDLE;
            end
        endcase
    end

    assign res.range_error = err_reg;
    assign res.max_value   = best_reg;

endmodule

// ----- test/range_max_segment_tree_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// range_max_segment_tree_checker
// watches the item, result and count channels of the range max segment tree,
// keeps its own max tree and count, and compares every result in order
// ----------------------------------------------------------------------------
module range_max_segment_tree_checker (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_tvalid,
    input  logic                       s_tready,
    input  logic [87:0]                s_tdata,  // position, value, range_low, range_high
    input  logic                       s_tuser,  // cmd
    input  logic                       m_tvalid,
    input  logic                       m_tready,
    input  logic [31:0]                m_tdata,  // max_value
    input  logic                       m_tuser,  // range_error
    input  logic                       cfg_valid,
    input  logic                       cfg_ready,
    input  logic [rmst_pkg::POS_W-1:0] cfg_data,
    output int                         mismatch_count,
    output int                         outstanding,
    output int                         writes_seen,
    output int                         queries_seen
);

    localparam int unsigned CAP     = rmst_pkg::CAPACITY_DEF;
    localparam int          VALUE_W = rmst_pkg::VALUE_W;
    localparam int          POS_W   = rmst_pkg::POS_W;

    logic [VALUE_W-1:0] node_max [2*CAP];
    logic [POS_W-1:0]   count_reg;
    rmst_pkg::result_t  pending_answers[$];
    int                 n_bad;
    int                 n_writes;
    int                 n_queries;

    function automatic int unsigned live_count();
        return (count_reg > CAP) ? CAP : int'(count_reg);
    endfunction

    function automatic logic [VALUE_W-1:0] larger(logic [VALUE_W-1:0] a,
                                                  logic [VALUE_W-1:0] b);
        return (a > b) ? a : b;
    endfunction

    function automatic void store_value(int unsigned pos, logic [VALUE_W-1:0] val);
        int unsigned node;
        node = CAP + pos - 1;
        node_max[node] = val;
        while (node > 1) begin
            node = node >> 1;
            node_max[node] = larger(node_max[2*node], node_max[2*node+1]);
        end
    endfunction

    function automatic logic [VALUE_W-1:0] range_peak(int unsigned lo, int unsigned hi);
        int unsigned        left;
        int unsigned        right;
        logic [VALUE_W-1:0] best;
        left  = CAP + lo - 1;
        right = CAP + hi;
        best  = '0;
        while (left < right) begin
            if ((left & 1) != 0) begin
                best = larger(best, node_max[left]);
                left++;
            end
            if ((right & 1) != 0) begin
                right--;
                best = larger(best, node_max[right]);
            end
            left  = left >> 1;
            right = right >> 1;
        end
        return best;
    endfunction

    always @(posedge aclk) begin
        rmst_pkg::item_t   req;
        rmst_pkg::result_t want;
        int unsigned       live;
        if (!aresetn) begin
            for (int k = 0; k < 2*CAP; k++)
                node_max[k] = '0;
            count_reg = rmst_pkg::COUNT_RESET;
            pending_answers.delete();
            n_bad     = 0;
            n_writes  = 0;
            n_queries = 0;
        end else begin
            if (cfg_valid && cfg_ready)
                count_reg = cfg_data;

            if (m_tvalid && m_tready) begin
                if (pending_answers.size() == 0) begin
                    $error("result with none expected: max_value %0d range_error %0d",
                           m_tdata[VALUE_W-1:0], m_tuser);
                    n_bad++;
                end else begin
                    want = pending_answers.pop_front();
                    if (m_tdata[VALUE_W-1:0] !== want.max_value) begin
                        $error("max_value mismatch: expected %0d, actual %0d",
                               want.max_value, m_tdata[VALUE_W-1:0]);
                        n_bad++;
                    end
                    if (m_tuser !== want.range_error) begin
                        $error("range_error mismatch: expected %0d, actual %0d",
                               want.range_error, m_tuser);
                        n_bad++;
                    end
                end
            end

            if (s_tvalid && s_tready) begin
                req  = {s_tuser, s_tdata[81:0]};
                live = live_count();
                if (req.cmd == rmst_pkg::CMD_WRITE) begin
                    n_writes++;
                    if (req.position >= 1 && req.position <= live)
                        store_value(req.position, req.value);
                end else begin
                    n_queries++;
                    if (req.range_low == 0 || req.range_low > req.range_high ||
                        req.range_high > live) begin
                        want.max_value   = '0;
                        want.range_error = 1'b1;
                    end else begin
                        want.max_value   = range_peak(req.range_low, req.range_high);
                        want.range_error = 1'b0;
                    end
                    pending_answers.push_back(want);
                end
            end
        end
        mismatch_count <= n_bad;
        outstanding    <= pending_answers.size();
        writes_seen    <= n_writes;
        queries_seen   <= n_queries;
    end

endmodule

// ----- test/range_max_segment_tree_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// range_max_segment_tree_tb
// drives point writes and range max queries into the segment tree under a
// series of element_count settings, with random gaps and result stalls;
// the checker beside the block predicts and compares every result
// ----------------------------------------------------------------------------
module range_max_segment_tree_tb;

    localparam int CAP           = rmst_pkg::CAPACITY_DEF;
    localparam int VALUE_W       = rmst_pkg::VALUE_W;
    localparam int POS_W         = rmst_pkg::POS_W;
    localparam int IDLE_LIMIT    = 600000;
    localparam int SETTLE_CYCLES = 48;
    localparam int MAX_WAIT      = 17;

    logic              aclk      = 1'b0;
    logic              aresetn   = 1'b0;
    logic              s_tvalid  = 1'b0;
    logic              s_tready;
    logic [87:0]       s_tdata   = '0;  // position, value, range_low, range_high
    logic              s_tuser   = 1'b0;  // cmd
    logic              m_tvalid;
    logic              m_tready  = 1'b0;
    logic [31:0]       m_tdata;  // max_value
    logic              m_tuser;  // range_error
    logic              cfg_valid = 1'b0;
    logic              cfg_ready;
    logic [POS_W-1:0]  cfg_data  = '0;

    int mismatch_count;
    int outstanding;
    int writes_seen;
    int queries_seen;
    int quiet_cycles    = 0;
    int gap_free_left   = 0;
    int stall_free_left = 0;
    int hot_base        = 1;
    int settings_used   = 0;

    range_max_segment_tree dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    range_max_segment_tree_checker chk (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .s_tuser        (s_tuser),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .m_tuser        (m_tuser),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_data       (cfg_data),
        .mismatch_count (mismatch_count),
        .outstanding    (outstanding),
        .writes_seen    (writes_seen),
        .queries_seen   (queries_seen)
    );

    initial begin
        forever #4 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles + 1 >= IDLE_LIMIT) begin
            $display("FAIL range_max_segment_tree");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // result side: random stall before each item, with stall-free stretches
    initial begin
        int stall;
        forever begin
            if (stall_free_left > 0) begin
                stall_free_left--;
                stall = 0;
            end else if ($urandom_range(0, 99) < 3) begin
                stall_free_left = $urandom_range(20, 60);
                stall = 0;
            end else begin
                stall = $urandom_range(0, MAX_WAIT);
            end
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!(m_tvalid && m_tready));
        end
    end

    task automatic push_item(rmst_pkg::cmd_kind_t cmd, logic [POS_W-1:0] pos,
                             logic [VALUE_W-1:0] val,
                             logic [POS_W-1:0] lo, logic [POS_W-1:0] hi);
        rmst_pkg::item_t it;
        int              gap;
        if (gap_free_left > 0) begin
            gap_free_left--;
            gap = 0;
        end else if ($urandom_range(0, 99) < 3) begin
            gap_free_left = $urandom_range(20, 60);
            gap = 0;
        end else begin
            gap = $urandom_range(0, MAX_WAIT);
        end
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        it.cmd        = cmd;
        it.position   = pos;
        it.value      = val;
        it.range_low  = lo;
        it.range_high = hi;
        s_tuser  <= it.cmd;
        s_tdata  <= {6'b0, it[81:0]};
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic ask_range(logic [POS_W-1:0] lo, logic [POS_W-1:0] hi);
        push_item(rmst_pkg::CMD_QUERY, POS_W'($urandom), VALUE_W'($urandom), lo, hi);
    endtask

    task automatic put_value(logic [POS_W-1:0] pos, logic [VALUE_W-1:0] val);
        push_item(rmst_pkg::CMD_WRITE, pos, val, POS_W'($urandom), POS_W'($urandom));
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (outstanding != 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic set_count(logic [POS_W-1:0] c);
        wait_drained();
        cfg_data  <= c;
        cfg_valid <= 1'b1;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        settings_used++;
    endtask

    function automatic int pick_pos(int ne);
        int p;
        case ($urandom_range(0, 9))
            0: p = 1;
            1: p = ne;
            2, 3, 4, 5: begin
                p = hot_base + $urandom_range(0, 63);
                if (p > ne)
                    p = ne;
            end
            default: p = $urandom_range(1, ne);
        endcase
        return p;
    endfunction

    function automatic logic [VALUE_W-1:0] pick_val();
        logic [VALUE_W-1:0] v;
        v = VALUE_W'($urandom);
        case ($urandom_range(0, 9))
            0: v = '0;
            1: v = {VALUE_W{1'b1}};
            2, 3: v = VALUE_W'($urandom_range(0, 255));
            default: ;
        endcase
        return v;
    endfunction

    task automatic random_item(int ne);
        logic [POS_W-1:0]   pos;
        logic [POS_W-1:0]   lo;
        logic [POS_W-1:0]   hi;
        logic [VALUE_W-1:0] val;
        int                 roll;
        int                 t;
        pos  = POS_W'($urandom);
        val  = VALUE_W'($urandom);
        lo   = POS_W'($urandom);
        hi   = POS_W'($urandom);
        roll = $urandom_range(0, 99);
        if (ne == 0) begin
            push_item(roll < 50 ? rmst_pkg::CMD_WRITE : rmst_pkg::CMD_QUERY, pos, val, lo, hi);
        end else if (roll < 45) begin
            put_value(POS_W'(pick_pos(ne)), pick_val());
        end else if (roll < 88) begin
            lo = POS_W'(pick_pos(ne));
            case ($urandom_range(0, 4))
                0: t = lo;
                1: t = int'(lo) + $urandom_range(0, 31);
                2: t = ne;
                3: begin
                    lo = POS_W'(1);
                    t  = ne;
                end
                default: t = $urandom_range(int'(lo), ne);
            endcase
            if (t > ne)
                t = ne;
            ask_range(lo, POS_W'(t));
        end else begin
            case ($urandom_range(0, 5))
                0: put_value('0, val);
                1: put_value(POS_W'($urandom_range(ne + 1, 17'h1FFFF)), val);
                2: ask_range('0, hi);
                3: begin
                    t = $urandom_range(1, ne);
                    ask_range(POS_W'(t + $urandom_range(1, 100)), POS_W'(t));
                end
                4: ask_range(POS_W'($urandom_range(1, ne)),
                             POS_W'($urandom_range(ne + 1, 17'h1FFFF)));
                default: push_item(roll[0] ? rmst_pkg::CMD_QUERY : rmst_pkg::CMD_WRITE,
                                   pos, val, lo, hi);
            endcase
        end
    endtask

    initial begin
        logic [POS_W-1:0] counts [13];
        int               ne;
        counts = '{17'd1, 17'd2, 17'd3, 17'd17, 17'd256, 17'd1000, 17'd40000,
                   17'd65535, 17'd65536, 17'd65537, 17'h1FFFF, 17'd0, 17'd7};

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // reset count covers the whole capacity
        put_value(17'd1, {VALUE_W{1'b1}});
        put_value(17'd65536, 31'd5);
        put_value(17'd2, 31'd0);
        ask_range(17'd1, 17'd65536);
        ask_range(17'd65536, 17'd65536);
        ask_range(17'd1, 17'd1);
        ask_range(17'd2, 17'd65536);
        put_value(17'd0, 31'd123);
        put_value(17'd65537, 31'd77);
        put_value(17'h1FFFF, 31'd99);
        ask_range(17'd0, 17'd5);
        ask_range(17'd10, 17'd9);
        ask_range(17'd1, 17'd65537);
        ask_range(17'h1FFFF, 17'h1FFFF);
        put_value(17'd1, 31'd0);
        ask_range(17'd1, 17'd65536);
        put_value(17'd32768, 31'h40000000);
        ask_range(17'd32768, 17'd32769);
        ask_range(17'd32767, 17'd32768);
        ask_range(17'd1, 17'd32767);
        ask_range(17'd32769, 17'd65536);

        foreach (counts[k]) begin
            set_count(counts[k]);
            ne = (counts[k] > CAP) ? CAP : int'(counts[k]);
            hot_base = (ne > 64) ? $urandom_range(1, ne - 63) : 1;
            repeat (ne == 0 ? 40 : 140) random_item(ne);
        end

        wait_drained();
        $display("run covered %0d writes and %0d queries over %0d element_count settings",
                 writes_seen, queries_seen, settings_used);
        $display("results still awaited: %0d, mismatches: %0d", outstanding, mismatch_count);
        if (mismatch_count == 0 && outstanding == 0) begin
            $display("PASS range_max_segment_tree");
        end else begin
            $display("FAIL range_max_segment_tree");
        end
        $finish;
    end

endmodule
